[hdl/rgb_led_pulse_width_serializer_core_defines.svh]
// ----------------------------------------------------------------------------
// rgb_led_pulse_width_serializer_core_defines
// Assertion macros shared by the checker of the LED line serializer.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_PULSE_WIDTH_SERIALIZER_CORE_DEFINES_SVH
`define RGB_LED_PULSE_WIDTH_SERIALIZER_CORE_DEFINES_SVH

// Antecedent in one cycle implies consequent in the next, outside reset
`define RGBPWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbpws checker: next-cycle implication failed");

// Antecedent implies consequent in the same cycle, outside reset
`define RGBPWS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbpws checker: same-cycle implication failed");

// Next-cycle implication that also holds during reset
`define RGBPWS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rgbpws checker: implication across reset failed");

`endif

[hdl/rgbpws_pkg.sv]
// ----------------------------------------------------------------------------
// rgbpws_pkg
// Types, codes and defaults of the RGB LED pulse width serializer.
// ----------------------------------------------------------------------------
package rgbpws_pkg;

    // Defaults for the top level parameters
    localparam int BITS_PER_PIXEL_DEF = 24;
    localparam int COUNT_WIDTH_DEF    = 20;

    // Color fields
    localparam int COLOR_W = 8;
    localparam int RGB_W   = 3 * COLOR_W;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    // Register map (index = byte address / 4)
    localparam int CFG_NUM   = 6;
    localparam int CFG_IDX_W = $clog2(CFG_NUM);
    localparam int PADDR_W   = $clog2(4 * CFG_NUM);
    localparam int PDATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_RESET_HIGH = CFG_IDX_W'(5);

    // Register reset values
    localparam int ONE_HIGH_RST   = 48;
    localparam int ONE_LOW_RST    = 15;
    localparam int ZERO_HIGH_RST  = 15;
    localparam int ZERO_LOW_RST   = 48;
    localparam int RESET_LOW_RST  = 72000;
    localparam int RESET_HIGH_RST = 72000;

    // Line phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BIT_HIGH,
        PH_BIT_LOW,
        PH_RST_LOW,
        PH_RST_HIGH
    } t_phase;

    // Input transaction
    typedef struct packed {
        logic [1:0]         cmd;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic line_level;
        logic busy_res;
    } t_out;

endpackage

[hdl/rgb_led_pulse_width_serializer_core.sv]
// ----------------------------------------------------------------------------
// rgb_led_pulse_width_serializer_core
// One-wire LED data line encoder: pixel, reset and tick commands in, line
// level and busy flag out, timing registers on an APB-style port.
// ----------------------------------------------------------------------------
//  channel   | signals                                    | direction
//  ----------+--------------------------------------------+----------
//  input     | i_in_valid / o_in_ready / i_in_data        | in
//  result    | o_out_valid / i_out_ready / o_out_data     | out
//  config    | psel penable pwrite paddr pwdata prdata    | in/out
//
//  One transaction is taken per clock; its result is registered and shows
//  on the result channel in the next cycle if no older result is queued.
//  A two-entry result queue decouples the sides: input stalls only when
//  both entries hold results not yet taken.
//  Reset (synchronous, active low) empties the queue, idles the sequencer
//  and loads the register defaults.
// ----------------------------------------------------------------------------
module rgb_led_pulse_width_serializer_core #(
    parameter int BITS_PER_PIXEL = rgbpws_pkg::BITS_PER_PIXEL_DEF,
    parameter int COUNT_WIDTH    = rgbpws_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rgbpws_pkg::t_in                  i_in_data,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rgbpws_pkg::t_out                 o_out_data,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgbpws_pkg::PADDR_W-1:0]   paddr,
    input  logic [rgbpws_pkg::PDATA_W-1:0]   pwdata,
    output logic [rgbpws_pkg::PDATA_W-1:0]   prdata,
    output logic                             pready
);
    import rgbpws_pkg::*;

    logic [CFG_NUM-1:0][COUNT_WIDTH-1:0] r_cfg;
    logic [CFG_IDX_W-1:0]                w_idx;
    logic                                w_idx_ok;
    logic                                w_wr;

    t_out        r_q [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_fill, n_fill;
    logic        w_push, w_pop;
    t_out        w_result;

    // Register access
    assign w_idx    = paddr[PADDR_W-1:2];
    assign w_idx_ok = (int'(w_idx) < CFG_NUM);
    assign w_wr     = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = w_idx_ok ? PDATA_W'(r_cfg[w_idx]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ONE_HIGH]   <= COUNT_WIDTH'(ONE_HIGH_RST);
            r_cfg[REG_ONE_LOW]    <= COUNT_WIDTH'(ONE_LOW_RST);
            r_cfg[REG_ZERO_HIGH]  <= COUNT_WIDTH'(ZERO_HIGH_RST);
            r_cfg[REG_ZERO_LOW]   <= COUNT_WIDTH'(ZERO_LOW_RST);
            r_cfg[REG_RESET_LOW]  <= COUNT_WIDTH'(RESET_LOW_RST);
            r_cfg[REG_RESET_HIGH] <= COUNT_WIDTH'(RESET_HIGH_RST);
        end else if (w_wr && w_idx_ok) begin
            r_cfg[w_idx] <= pwdata[COUNT_WIDTH-1:0];
        end
    end

    // Handshakes
    assign o_in_ready  = (r_fill != 2'd2);
    assign o_out_valid = (r_fill != 2'd0);
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_out_valid && i_out_ready;

    // Line sequencer
    rgbpws_engine #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_push),
        .i_data      (i_in_data),
        .i_cfg_ticks (r_cfg),
        .o_result    (w_result)
    );

    // Result queue pointers
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ w_pop;
        n_fill   = r_fill + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_result;
        end
    end

    assign o_out_data = r_q[r_rd_ptr];

endmodule

[hdl/rgbpws_engine.sv]
// ----------------------------------------------------------------------------
// rgbpws_engine
// Phase sequencer of the LED line: shift register, bit counter and tick
// counter, updated once per accepted transaction.
// ----------------------------------------------------------------------------
module rgbpws_engine #(
    parameter int BITS_PER_PIXEL = rgbpws_pkg::BITS_PER_PIXEL_DEF,
    parameter int COUNT_WIDTH    = rgbpws_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_accept,
    input  rgbpws_pkg::t_in                               i_data,
    input  logic [rgbpws_pkg::CFG_NUM-1:0][COUNT_WIDTH-1:0] i_cfg_ticks,
    output rgbpws_pkg::t_out                              o_result
);
    import rgbpws_pkg::*;

    localparam int BL_W   = $clog2(BITS_PER_PIXEL + 1);
    localparam int WORD_W = (BITS_PER_PIXEL > RGB_W) ? BITS_PER_PIXEL : RGB_W;

    t_phase                    r_phase, n_phase;
    logic [BITS_PER_PIXEL-1:0] r_shift, n_shift;
    logic [BL_W-1:0]           r_bits, n_bits;
    logic [COUNT_WIDTH-1:0]    r_count, n_count;
    logic                      r_line, n_line;

    logic [WORD_W-1:0]         w_word;
    logic [BITS_PER_PIXEL-1:0] w_load;
    logic [BITS_PER_PIXEL-1:0] w_shifted;
    logic [BL_W-1:0]           w_bits_dec;
    logic [COUNT_WIDTH-1:0]    w_count_dec;
    logic                      w_idle;

    // a zero register value acts as a single tick
    function automatic logic [COUNT_WIDTH-1:0] nz(input logic [COUNT_WIDTH-1:0] v);
        nz = (v == '0) ? COUNT_WIDTH'(1) : v;
    endfunction

    // Datapath helpers
    assign w_word      = WORD_W'({i_data.red, i_data.green, i_data.blue});
    assign w_load      = w_word[BITS_PER_PIXEL-1:0];
    assign w_shifted   = {r_shift[BITS_PER_PIXEL-2:0], 1'b0};
    assign w_bits_dec  = r_bits - BL_W'(1);
    assign w_count_dec = r_count - COUNT_WIDTH'(1);
    assign w_idle      = (r_phase == PH_IDLE);

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_count = r_count;
        n_line  = r_line;
        if (i_accept) begin
            if (i_data.cmd == CMD_TICK && !w_idle) begin
                n_count = w_count_dec;
                if (w_count_dec == '0) begin
                    case (r_phase)
                        PH_BIT_HIGH: begin
                            n_phase = PH_BIT_LOW;
                            n_line  = 1'b0;
                            n_count = nz(r_shift[BITS_PER_PIXEL-1]
                                         ? i_cfg_ticks[REG_ONE_LOW]
                                         : i_cfg_ticks[REG_ZERO_LOW]);
                        end
                        PH_BIT_LOW: begin
                            n_shift = w_shifted;
                            n_bits  = w_bits_dec;
                            if (w_bits_dec == '0) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_phase = PH_BIT_HIGH;
                                n_line  = 1'b1;
                                n_count = nz(w_shifted[BITS_PER_PIXEL-1]
                                             ? i_cfg_ticks[REG_ONE_HIGH]
                                             : i_cfg_ticks[REG_ZERO_HIGH]);
                            end
                        end
                        PH_RST_LOW: begin
                            n_phase = PH_RST_HIGH;
                            n_line  = 1'b1;
                            n_count = nz(i_cfg_ticks[REG_RESET_HIGH]);
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end else if (i_data.cmd == CMD_PIXEL && w_idle) begin
                n_shift = w_load;
                n_bits  = BL_W'(BITS_PER_PIXEL);
                n_phase = PH_BIT_HIGH;
                n_line  = 1'b1;
                n_count = nz(w_load[BITS_PER_PIXEL-1]
                             ? i_cfg_ticks[REG_ONE_HIGH]
                             : i_cfg_ticks[REG_ZERO_HIGH]);
            end else if (i_data.cmd == CMD_RESET && w_idle) begin
                n_phase = PH_RST_LOW;
                n_line  = 1'b0;
                n_count = nz(i_cfg_ticks[REG_RESET_LOW]);
            end
        end
    end

    // Result of the transaction being accepted
    always_comb begin
        o_result.line_level = n_line;
        o_result.busy_res   = (n_phase != PH_IDLE);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_shift <= '0;
            r_bits  <= '0;
            r_count <= '0;
            r_line  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_count <= n_count;
            r_line  <= n_line;
        end
    end

endmodule

[hdl/rgbpws_checker.sv]
// ----------------------------------------------------------------------------
// rgbpws_checker
// Port-level checks of the LED line serializer, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_led_pulse_width_serializer_core_defines.svh"

module rgbpws_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input rgbpws_pkg::t_out o_out_data
);
    import rgbpws_pkg::*;

    // a stalled result holds its value
    `RGBPWS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // an accepted transaction always yields a result in the next cycle
    `RGBPWS_ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)

    // an empty result side never blocks the input
    `RGBPWS_ASSERT_SAME(a_empty_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // reset leaves the queue empty and the input open
    `RGBPWS_ASSERT_ALWAYS_NEXT(a_reset_open, i_clk, !i_rst_n, o_in_ready && !o_out_valid)

endmodule

bind rgb_led_pulse_width_serializer_core rgbpws_checker u_rgbpws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
